### sv/fibonacci_exponent_product_mod_core_assert.svh
// Assertion macros for the Fibonacci exponent product core.
// Included by the modules that check their own control logic.
`ifndef FIBONACCI_EXPONENT_PRODUCT_MOD_CORE_ASSERT_SVH
`define FIBONACCI_EXPONENT_PRODUCT_MOD_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define FEPM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define FEPM_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define FEPM_ASSERT(label, clk, rst_n, prop)
`define FEPM_ASSERT_RST(label, clk, prop)
`endif
`endif

### sv/fepm_pkg.sv
// Shared constants and types for the Fibonacci exponent product core.
// No dependencies.
package fepm_pkg;
  localparam int unsigned DayBitsDef = 64;
  localparam int unsigned ModBitsDef = 31;
  localparam int unsigned SeedBits = 32;
  localparam int unsigned DayFieldBits = 63;
  localparam int unsigned ModFieldBits = 31;
  localparam logic [30:0] ModResetVal = 31'd1000000007;

  // multiplier request from sequencer
  typedef struct packed {
    logic start;
    logic busy;
  } mul_ctl_t;
endpackage

### sv/fibonacci_exponent_product_mod_core.sv
// Fibonacci exponent product modulo p: top level with handshakes and register.
// Depends on fepm_pkg, fepm_seq, assertion header.
// Steps in order: seed reduction, matrix powering, then exponentiation; all modular
// products share the one bit-serial multiplier. One beat in flight; next input
// taken the cycle after the result beat. Reset: async active low, modulus back
// to 1000000007, core idle.
`include "fibonacci_exponent_product_mod_core_assert.svh"
module fibonacci_exponent_product_mod_core #(
  parameter int unsigned DayBits = fepm_pkg::DayBitsDef,
  parameter int unsigned ModBits = fepm_pkg::ModBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] first_seed_i,
  input  logic [31:0] second_seed_i,
  input  logic [62:0] day_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [30:0] day_value_o
);
  logic [30:0] pmod_q;
  logic busy_q, ovld_q;
  logic [30:0] oval_q;
  logic go, sdone;
  logic [ModBits-1:0] sres;
  logic [DayBits-1:0] nday;
  logic [63:0] day_ext;

  // day index widened then trimmed to DayBits
  assign day_ext = {1'b0, day_index_i};
  assign nday = day_ext[DayBits-1:0];
  assign in_ready_o = !busy_q;
  assign go = in_valid_i && in_ready_o;

  fepm_seq #(.DayBits(DayBits), .ModBits(ModBits)) u_seq (
    .clk_i, .rst_ni, .go_i(go), .f1_i(first_seed_i), .f2_i(second_seed_i),
    .n_i(nday), .p_i(pmod_q[ModBits-1:0]), .done_o(sdone), .res_o(sres));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pmod_q <= fepm_pkg::ModResetVal; busy_q <= 1'b0; ovld_q <= 1'b0;
    end else begin
      if (cfg_we_i) pmod_q <= cfg_wdata_i & 31'((64'd1 << ModBits) - 1);
      if (go) busy_q <= 1'b1;
      else if (ovld_q && out_ready_i) busy_q <= 1'b0;
      if (sdone) ovld_q <= 1'b1;
      else if (out_ready_i) ovld_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (sdone) oval_q <= 31'(sres);
  end
  assign out_valid_o = ovld_q;
  assign day_value_o = oval_q;

  `FEPM_ASSERT(a_out_busy, clk_i, rst_ni, ovld_q |-> busy_q)
  `FEPM_ASSERT(a_one_go, clk_i, rst_ni, go |=> !in_ready_o)
  `FEPM_ASSERT(a_done_busy, clk_i, rst_ni, sdone |-> (busy_q && !ovld_q))
endmodule

### sv/fepm_mulmod.sv
// Bit-serial modular multiplier: r = a*b mod m, one bit of b per cycle.
// Depends on fepm_pkg, assertion header.
`include "fibonacci_exponent_product_mod_core_assert.svh"
module fepm_mulmod #(
  parameter int unsigned ModBits = fepm_pkg::ModBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [ModBits-1:0] a_i,
  input  logic [ModBits-1:0] b_i,
  input  logic [ModBits-1:0] m_i,
  output logic               done_o,
  output logic [ModBits-1:0] r_o
);
  localparam int unsigned CntW = $clog2(ModBits + 1);
  logic [ModBits-1:0] acc_q, acc_d, b_q, b_d, a_q, a_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [ModBits:0]   dbl, dsum;
  logic [ModBits-1:0] dred;

  // with acc and a below m, doubled or summed values stay below 2m
  always_comb begin
    acc_d = acc_q; b_d = b_q; a_d = a_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    dbl = {acc_q, 1'b0};
    if (dbl >= {1'b0, m_i}) dbl = dbl - {1'b0, m_i};
    dsum = dbl + {1'b0, a_q};
    if (b_q[ModBits-1] && (dsum >= {1'b0, m_i})) dsum = dsum - {1'b0, m_i};
    dred = b_q[ModBits-1] ? dsum[ModBits-1:0] : dbl[ModBits-1:0];
    if (start_i) begin
      acc_d = '0; b_d = b_i; a_d = a_i; cnt_d = CntW'(ModBits); busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = dred; b_d = {b_q[ModBits-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; b_q <= b_d; a_q <= a_d;
  end
  assign done_o = done_q;
  assign r_o = acc_q;

  `FEPM_ASSERT(a_done_after_busy, clk_i, rst_ni, done_q |-> $past(busy_q))
  `FEPM_ASSERT(a_cnt_idle, clk_i, rst_ni, (!busy_q && !start_i) |=> !busy_q)
  `FEPM_ASSERT(a_no_done_busy, clk_i, rst_ni, done_q |-> !busy_q)
endmodule

### sv/fepm_seq.sv
// Sequencer: seed reduction, matrix powering, square-and-multiply and final fix-ups.
// Depends on fepm_pkg, fepm_mulmod, assertion header.
`include "fibonacci_exponent_product_mod_core_assert.svh"
module fepm_seq #(
  parameter int unsigned DayBits = fepm_pkg::DayBitsDef,
  parameter int unsigned ModBits = fepm_pkg::ModBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               go_i,
  input  logic [31:0]        f1_i,
  input  logic [31:0]        f2_i,
  input  logic [DayBits-1:0] n_i,
  input  logic [ModBits-1:0] p_i,
  output logic               done_o,
  output logic [ModBits-1:0] res_o
);
  localparam int unsigned ECW = $clog2(ModBits + 1);
  localparam int unsigned RCW = $clog2(33);
  localparam logic [4:0] S_IDLE = 5'd0, S_RED = 5'd1, S_FBIT = 5'd2, S_RM = 5'd3,
    S_RA = 5'd4, S_BM = 5'd5, S_BA = 5'd6, S_FIX = 5'd7, S_EBIT = 5'd8, S_EMUL = 5'd9,
    S_ESQ = 5'd10, S_PROD = 5'd11, S_OUT = 5'd12, S_MW = 5'd13;

  logic [4:0] st_q, st_d, ret_q, ret_d;
  logic [DayBits-1:0] n_q, n_d, nsh_q, nsh_d;
  logic [ModBits-1:0] p_q, p_d, q_q, q_d;
  logic [ModBits-1:0] ra_q, ra_d, rb_q, rb_d;   // seed residues
  logic [31:0] sa_q, sa_d, sb_q, sb_d;          // seed bits, MSB first
  logic [RCW-1:0] rc_q, rc_d;
  logic [ModBits-1:0] r0_q, r0_d, r1_q, r1_d, r2_q, r2_d, r3_q, r3_d;
  logic [ModBits-1:0] b0_q, b0_d, b1_q, b1_d, b2_q, b2_d, b3_q, b3_d;
  logic [ModBits-1:0] t0_q, t0_d, t1_q, t1_d, t2_q, t2_d, t3_q, t3_d;
  logic [2:0] ph_q, ph_d;
  logic [ModBits-1:0] eb_q, eb_d, ba_q, ba_d, bb_q, bb_d;
  logic [ModBits-1:0] acc_q, acc_d, sq_q, sq_d, pa_q, pa_d;
  logic [ModBits-1:0] ex_q, ex_d;
  logic [ECW-1:0] ec_q, ec_d;
  logic which_q, which_d;
  logic [ModBits-1:0] res_q, res_d;
  logic done_q, done_d;
  logic kick_q, kick_d;
  logic mstart, mdone;
  logic [ModBits-1:0] ma, mb, mm, mr, ma_q, ma_d, mb_q, mb_d, mm_q, mm_d;
  logic [ModBits:0] add_s;
  logic [ModBits-1:0] add_r;
  logic [ModBits:0] ta, tb;
  fepm_pkg::mul_ctl_t ctl;

  fepm_mulmod #(.ModBits(ModBits)) u_mul (
    .clk_i, .rst_ni, .start_i(mstart), .a_i(ma), .b_i(mb), .m_i(mm),
    .done_o(mdone), .r_o(mr));

  assign ma = ma_q; assign mb = mb_q; assign mm = mm_q;
  // one start pulse on the first cycle of each multiplier wait
  assign ctl.start = kick_q;
  assign ctl.busy = (st_q == S_MW);
  assign mstart = ctl.start;

  // matrix term products: phase 0..7 -> operand pair of the 2x2 product
  function automatic logic [2*ModBits-1:0] mpair(input logic [2:0] k,
      input logic [ModBits-1:0] x0, x1, x2, x3, y0, y1, y2, y3);
    logic [ModBits-1:0] a, b;
    begin
      a = '0; b = '0;
      case (k)
        3'd0: begin a = x0; b = y0; end
        3'd1: begin a = x1; b = y2; end
        3'd2: begin a = x0; b = y1; end
        3'd3: begin a = x1; b = y3; end
        3'd4: begin a = x2; b = y0; end
        3'd5: begin a = x3; b = y2; end
        3'd6: begin a = x2; b = y1; end
        3'd7: begin a = x3; b = y3; end
        default: begin a = '0; b = '0; end
      endcase
      mpair = {a, b};
    end
  endfunction

  always_comb begin
    add_s = {1'b0, t0_q} + {1'b0, mr};
    if (add_s >= {1'b0, q_q}) add_s = add_s - {1'b0, q_q};
    add_r = add_s[ModBits-1:0];
    // one step of seed reduction: shift in next bit, subtract p once
    ta = {ra_q, sa_q[31]};
    if (ta >= {1'b0, p_q}) ta = ta - {1'b0, p_q};
    tb = {rb_q, sb_q[31]};
    if (tb >= {1'b0, p_q}) tb = tb - {1'b0, p_q};
  end

  always_comb begin
    st_d = st_q; ret_d = ret_q; n_d = n_q; nsh_d = nsh_q; p_d = p_q; q_d = q_q;
    ra_d = ra_q; rb_d = rb_q; sa_d = sa_q; sb_d = sb_q; rc_d = rc_q;
    r0_d = r0_q; r1_d = r1_q; r2_d = r2_q; r3_d = r3_q;
    b0_d = b0_q; b1_d = b1_q; b2_d = b2_q; b3_d = b3_q;
    t0_d = t0_q; t1_d = t1_q; t2_d = t2_q; t3_d = t3_q;
    ph_d = ph_q; eb_d = eb_q; ba_d = ba_q; bb_d = bb_q;
    acc_d = acc_q; sq_d = sq_q; pa_d = pa_q; ex_d = ex_q; ec_d = ec_q;
    which_d = which_q; res_d = res_q; done_d = 1'b0; kick_d = 1'b0;
    ma_d = ma_q; mb_d = mb_q; mm_d = mm_q;
    case (st_q)
      S_IDLE: begin
        if (go_i) begin
          n_d = n_i; nsh_d = n_i; p_d = p_i; q_d = p_i - 1'b1;
          ra_d = '0; rb_d = '0; sa_d = f1_i; sb_d = f2_i; rc_d = RCW'(32);
          st_d = S_RED;
        end
      end
      S_RED: begin
        // seeds reduced mod p, one bit per cycle
        if ((rc_q != '0) && (p_q > ModBits'(1))) begin
          ra_d = ta[ModBits-1:0]; rb_d = tb[ModBits-1:0];
          sa_d = {sa_q[30:0], 1'b0}; sb_d = {sb_q[30:0], 1'b0};
          rc_d = rc_q - 1'b1;
        end else if (p_q < ModBits'(2)) begin
          res_d = '0; st_d = S_OUT;
        end else if (n_q == '0) begin
          res_d = ra_q; st_d = S_OUT;
        end else begin
          r0_d = (q_q == ModBits'(1)) ? '0 : ModBits'(1);
          r1_d = '0; r2_d = '0; r3_d = r0_d;
          b0_d = r0_d; b1_d = r0_d; b2_d = r0_d; b3_d = '0;
          ba_d = (ra_q == p_q - 1'b1) ? '0 : ra_q + 1'b1;
          bb_d = (rb_q == p_q - 1'b1) ? '0 : rb_q + 1'b1;
          st_d = S_FBIT;
        end
      end
      S_FBIT: begin
        if (nsh_q == '0) st_d = S_FIX;
        else begin
          ph_d = '0;
          st_d = nsh_q[0] ? S_RM : S_BM;
        end
      end
      S_RM, S_BM: begin
        // issue product ph; even phases hold, odd add into entry
        {ma_d, mb_d} = (st_q == S_RM) ?
          mpair(ph_q, r0_q, r1_q, r2_q, r3_q, b0_q, b1_q, b2_q, b3_q) :
          mpair(ph_q, b0_q, b1_q, b2_q, b3_q, b0_q, b1_q, b2_q, b3_q);
        mm_d = q_q; ret_d = (st_q == S_RM) ? S_RA : S_BA;
        kick_d = 1'b1; st_d = S_MW;
      end
      S_MW: begin
        if (mdone) st_d = ret_q;
      end
      S_RA, S_BA: begin
        if (!ph_q[0]) t0_d = mr;
        else begin
          case (ph_q[2:1])
            2'd0: t1_d = add_r;
            2'd1: t2_d = add_r;
            2'd2: t3_d = add_r;
            default: begin
              if (st_q == S_RA) begin
                r0_d = t1_q; r1_d = t2_q; r2_d = t3_q; r3_d = add_r;
              end else begin
                b0_d = t1_q; b1_d = t2_q; b2_d = t3_q; b3_d = add_r;
              end
            end
          endcase
        end
        if (ph_q == 3'd7) begin
          if (st_q == S_RA) st_d = S_BM;
          else begin nsh_d = nsh_q >> 1; st_d = S_FBIT; end
          ph_d = '0;
        end else begin
          ph_d = ph_q + 3'd1;
          st_d = (st_q == S_RA) ? S_RM : S_BM;
        end
      end
      S_FIX: begin
        eb_d = (r1_q == '0) ? q_q : r1_q;
        which_d = 1'b0; st_d = S_EBIT;
        acc_d = ModBits'(1); sq_d = ba_q;
        ex_d = ((r3_q == '0) && (n_q > DayBits'(1))) ? q_q : r3_q;
        ec_d = ECW'(ModBits);
      end
      S_EBIT: begin
        if (ec_q == '0) begin
          if (!which_q) begin
            pa_d = acc_q; which_d = 1'b1; acc_d = ModBits'(1); sq_d = bb_q;
            ex_d = eb_q; ec_d = ECW'(ModBits);
          end else begin
            ma_d = pa_q; mb_d = acc_q; mm_d = p_q; ex_d = '0; kick_d = 1'b1;
            ret_d = S_PROD; st_d = S_MW;
          end
        end else if (ex_q[0]) begin
          ma_d = acc_q; mb_d = sq_q; mm_d = p_q; kick_d = 1'b1;
          ret_d = S_EMUL; st_d = S_MW;
        end else begin
          ma_d = sq_q; mb_d = sq_q; mm_d = p_q; kick_d = 1'b1;
          ret_d = S_ESQ; st_d = S_MW;
        end
      end
      S_EMUL: begin
        acc_d = mr; ma_d = sq_q; mb_d = sq_q; mm_d = p_q; kick_d = 1'b1;
        ret_d = S_ESQ; st_d = S_MW;
      end
      S_ESQ: begin
        sq_d = mr; ex_d = ex_q >> 1; ec_d = ec_q - 1'b1; st_d = S_EBIT;
      end
      S_PROD: begin
        res_d = (mr == '0) ? p_q - 1'b1 : mr - 1'b1; st_d = S_OUT;
      end
      S_OUT: begin
        done_d = 1'b1; st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; done_q <= 1'b0; ph_q <= '0; kick_q <= 1'b0;
    end else begin
      st_q <= st_d; done_q <= done_d; ph_q <= ph_d; kick_q <= kick_d;
    end
  end
  always_ff @(posedge clk_i) begin
    ret_q <= ret_d; n_q <= n_d; nsh_q <= nsh_d; p_q <= p_d; q_q <= q_d;
    ra_q <= ra_d; rb_q <= rb_d; sa_q <= sa_d; sb_q <= sb_d; rc_q <= rc_d;
    r0_q <= r0_d; r1_q <= r1_d; r2_q <= r2_d; r3_q <= r3_d;
    b0_q <= b0_d; b1_q <= b1_d; b2_q <= b2_d; b3_q <= b3_d;
    t0_q <= t0_d; t1_q <= t1_d; t2_q <= t2_d; t3_q <= t3_d;
    eb_q <= eb_d; ba_q <= ba_d; bb_q <= bb_d;
    acc_q <= acc_d; sq_q <= sq_d; pa_q <= pa_d; ex_q <= ex_d; ec_q <= ec_d;
    which_q <= which_d; res_q <= res_d; ma_q <= ma_d; mb_q <= mb_d; mm_q <= mm_d;
  end
  assign done_o = done_q;
  assign res_o = res_q;

  `FEPM_ASSERT(a_done_from_out, clk_i, rst_ni, done_q |-> $past(st_q == S_OUT))
  `FEPM_ASSERT(a_start_in_wait, clk_i, rst_ni, ctl.start |-> ctl.busy)
  `FEPM_ASSERT(a_go_idle, clk_i, rst_ni, (go_i && st_q == S_IDLE) |=> st_q == S_RED)
endmodule

### test/tb_fibonacci_exponent_product_mod_core.sv
// Testbench for fibonacci_exponent_product_mod_core: random and directed day requests.
// Depends on fepm_pkg and the core RTL; predicts each day value and checks it in order.
`timescale 1ns / 1ps

module tb_fibonacci_exponent_product_mod_core;
  typedef longint unsigned u64_t;
  typedef u64_t mat2_t [4];

  // Expected day values, oldest first, plus the modulus the core holds now.
  class day_value_board;
    u64_t       modulus;
    logic [30:0] pending_q [$];
    int         errors;

    function new();
      modulus = 64'(fepm_pkg::ModResetVal);
      errors  = 0;
    endfunction

    function void mat_mul(input mat2_t a, input mat2_t b, output mat2_t c, input u64_t q);
      c[0] = (a[0] * b[0] % q + a[1] * b[2] % q) % q;
      c[1] = (a[0] * b[1] % q + a[1] * b[3] % q) % q;
      c[2] = (a[2] * b[0] % q + a[3] * b[2] % q) % q;
      c[3] = (a[2] * b[1] % q + a[3] * b[3] % q) % q;
    endfunction

    function u64_t pow_mod(u64_t base, u64_t ex, u64_t m);
      u64_t acc;
      u64_t sq;
      acc = 1 % m;
      sq  = base % m;
      while (ex != 0) begin
        if (ex[0]) acc = acc * sq % m;
        sq = sq * sq % m;
        ex = ex >> 1;
      end
      return acc;
    endfunction

    function logic [30:0] day_value(logic [31:0] f1, logic [31:0] f2, logic [62:0] n);
      u64_t  p, q, ea, eb, ba, bb, prod, k;
      mat2_t acc, bas, tmp;
      p = modulus & 64'h7FFF_FFFF;
      if (p < 2) return '0;
      if (n == 0) return 31'(u64_t'(f1) % p);
      q = p - 1;
      // Fib(n) / Fib(n-1) mod q by matrix powering
      acc = '{1 % q, 0, 0, 1 % q};
      bas = '{1 % q, 1 % q, 1 % q, 0};
      k = u64_t'(n);
      while (k != 0) begin
        if (k[0]) begin
          mat_mul(acc, bas, tmp, q);
          acc = tmp;
        end
        mat_mul(bas, bas, tmp, q);
        bas = tmp;
        k = k >> 1;
      end
      eb = acc[1];
      ea = acc[3];
      // zero residue of a positive exponent stands for p-1
      if (eb == 0) eb = q;
      if (ea == 0 && n >= 2) ea = q;
      ba = (u64_t'(f1) % p + 1) % p;
      bb = (u64_t'(f2) % p + 1) % p;
      prod = pow_mod(ba, ea, p) * pow_mod(bb, eb, p) % p;
      return 31'((prod + p - 1) % p);
    endfunction

    function void note_request(logic [31:0] f1, logic [31:0] f2, logic [62:0] n);
      pending_q.push_back(day_value(f1, f2, n));
    endfunction

    function void check_result(logic [30:0] got);
      logic [30:0] want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected day_value %0d", $time, got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        $display("%0t: day_value mismatch expected %0d actual %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [30:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] first_seed_i = '0;
  logic [31:0] second_seed_i = '0;
  logic [62:0] day_index_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [30:0] day_value_o;

  day_value_board board = new();
  int  burst_left = 0;
  bit  long_hold_req = 1'b0;

  always #2 clk_i = ~clk_i;

  fibonacci_exponent_product_mod_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .first_seed_i, .second_seed_i, .day_index_i,
    .out_valid_o, .out_ready_i, .day_value_o
  );

  // Offer one request beat; returns at the edge that took it, valid still high.
  task automatic send_day(logic [31:0] f1, logic [31:0] f2, logic [62:0] n);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 8);
    end
    in_valid_i    <= 1'b1;
    first_seed_i  <= f1;
    second_seed_i <= f2;
    day_index_i   <= n;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(f1, f2, n);
    burst_left--;
  endtask

  // Drain, then write the modulus while the core sits idle.
  task automatic write_modulus(logic [30:0] v);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.modulus = 64'(v);
  endtask

  // Mostly short days keep the run fast; a few span all 63 bits.
  function automatic logic [62:0] rand_day();
    logic [62:0] raw;
    int w;
    raw = 63'({$urandom, $urandom});
    w = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 12) : $urandom_range(13, 63);
    return raw & ((63'd1 << w) - 63'd1);
  endfunction

  function automatic logic [31:0] rand_seed();
    u64_t p;
    p = board.modulus;
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 32'(p - 1);            // base becomes zero mod p
      3: return 32'(p * $urandom_range(1, 3) - 1);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_days(int count);
    repeat (count) send_day(rand_seed(), rand_seed(), rand_day());
  endtask

  task automatic directed_days();
    logic [31:0] pm1;
    pm1 = 32'(board.modulus - 1);
    send_day(32'd5, 32'd7, 63'd0);        // day zero returns f1 mod p
    send_day('1, 32'd7, 63'd0);
    send_day(32'd2, 32'd3, 63'd1);
    send_day(32'd2, 32'd3, 63'd2);
    send_day('0, '0, 63'd3);
    send_day('1, '1, '1);                 // widest day index
    send_day(pm1, 32'd9, 63'd10);         // base zero, exponents stay nonzero
    send_day(32'd9, pm1, 63'd11);
  endtask

  // Receiver: random stall pattern, one long hold-off on request.
  initial begin
    int hold;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) board.check_result(day_value_o);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        // longer than the slowest beat, so a result waits and input stalls
        for (hold = 0; hold < 60000; hold++) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 3) != 0) || ($time % 2000 < 400);
      end
    end
  end

  initial begin
    #400_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // reset modulus first, then the extremes and odd cases
    directed_days();
    long_hold_req = 1'b1;
    random_days(16);
    write_modulus(31'd3);
    directed_days();
    random_days(12);
    write_modulus(31'h7FFF_FFFF);
    directed_days();
    random_days(16);
    write_modulus(31'd2);
    random_days(8);
    write_modulus(31'd0);
    random_days(4);
    write_modulus(31'd1);
    random_days(4);
    write_modulus(31'd1000000006);        // composite
    random_days(10);
    write_modulus(31'($urandom_range(3, 32'h7FFF_FFFF)));
    random_days(10);
    write_modulus(fepm_pkg::ModResetVal);
    random_days(16);
    in_valid_i <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
